// File: sv/mar_pkg.sv
// ----------------------------------------------------------------------------
// mar_pkg
// Shared constants for the bar-range moving average: register map, default
// parameter values and fixed field widths.
// ----------------------------------------------------------------------------
package mar_pkg;

   // defaults for the top-level parameters
   localparam int MAX_PERIOD_DEF = 256;
   localparam int PRICE_BITS_DEF = 32;

   // fixed field widths
   localparam int PERIOD_W  = 9;
   localparam int START_W   = 32;
   localparam int COUNT_W   = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 1;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INDEX = 1'd1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd30;
   localparam logic [START_W-1:0]  START_RESET  = '0;

   // job queue between the front and the divider
   localparam int QUEUE_DEPTH = 2;

endpackage

// File: sv/mar_ram.sv
// ----------------------------------------------------------------------------
// mar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mar_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/mar_front.sv
// ----------------------------------------------------------------------------
// mar_front
// Front end: takes price bars, keeps the range ring and running window sum,
// decides whether a bar yields an average and queues a divide job for it.
// ----------------------------------------------------------------------------
module mar_front #(
   parameter int MAX_PERIOD = mar_pkg::MAX_PERIOD_DEF,
   parameter int PRICE_BITS = mar_pkg::PRICE_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // bar input
   input  logic                                           req_valid,
   output logic                                           req_ready,
   input  logic [PRICE_BITS-1:0]                          req_high_price,
   input  logic [PRICE_BITS-1:0]                          req_low_price,
   input  logic                                           req_is_last,
   // register writes
   input  logic                                           csr_we,
   input  logic [mar_pkg::CSR_IDX_W-1:0]                  csr_index,
   input  logic [mar_pkg::CSR_W-1:0]                      csr_wdata,
   // job queue
   input  logic                                           job_full,
   output logic                                           job_push,
   output logic signed [PRICE_BITS+$clog2(MAX_PERIOD):0]  job_total,
   output logic [$clog2(MAX_PERIOD+1)-1:0]                job_period,
   output logic [mar_pkg::COUNT_W-1:0]                    job_bar,
   output logic [mar_pkg::COUNT_W-1:0]                    job_number,
   output logic                                           job_last
);

   import mar_pkg::*;

   localparam int PW = $clog2(MAX_PERIOD + 1);
   localparam int AW = $clog2(MAX_PERIOD);
   localparam int RW = PRICE_BITS + 1;
   localparam int SW = RW + $clog2(MAX_PERIOD);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_READ = 3'b010,
      F_UPD  = 3'b100
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [START_W-1:0]    start_ff, start_in;
   logic signed [SW-1:0]  sum_ff, sum_in;
   logic [COUNT_W-1:0]    bar_ff, bar_in;
   logic [COUNT_W-1:0]    emitted_ff, emitted_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [PW-1:0]         held_ff, held_in;
   logic [AW-1:0]         oldest_ff, oldest_in;

   logic [PW-1:0]         eff_period;
   logic signed [RW-1:0]  bar_range;
   logic signed [SW-1:0]  total;
   logic [PW-1:0]         held_next;
   logic                  fill;
   logic                  emit;
   logic                  accept;
   logic [PW:0]           ptr_wide, back_wide, oldest_wide;
   logic [AW-1:0]         ptr_next;
   logic [RW-1:0]         ring_rdata;
   logic signed [SW-1:0]  oldest_range;

   // period 0 acts as 1, oversized values saturate
   always_comb begin
      if (period_ff == '0) begin
         eff_period = PW'(1);
      end else if (32'(period_ff) > 32'(MAX_PERIOD)) begin
         eff_period = PW'(MAX_PERIOD);
      end else begin
         eff_period = PW'(period_ff);
      end
   end

   assign bar_range = $signed({1'b0, req_high_price}) - $signed({1'b0, req_low_price});
   assign total     = sum_ff + {{(SW-RW){bar_range[RW-1]}}, bar_range};
   assign held_next = (held_ff == PW'(MAX_PERIOD)) ? held_ff : held_ff + PW'(1);
   assign fill      = held_next >= eff_period;
   assign emit      = fill && (bar_ff >= start_ff);

   assign req_ready = (state_ff == F_IDLE) && !job_full;
   assign accept    = req_valid && req_ready;

   // oldest entry of the window, counted back from the slot just written
   always_comb begin
      ptr_wide  = (PW+1)'(ptr_ff);
      back_wide = (PW+1)'(eff_period) - (PW+1)'(1);
      if (ptr_wide >= back_wide) begin
         oldest_wide = ptr_wide - back_wide;
      end else begin
         oldest_wide = ptr_wide + (PW+1)'(MAX_PERIOD) - back_wide;
      end
   end

   assign ptr_next = (ptr_ff == AW'(MAX_PERIOD - 1)) ? '0 : ptr_ff + AW'(1);

   mar_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_PERIOD)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_ff),
      .wr_data (bar_range),
      .rd_en   (state_ff == F_READ),
      .rd_addr (oldest_ff),
      .rd_data (ring_rdata)
   );

   assign oldest_range = {{(SW-RW){ring_rdata[RW-1]}}, ring_rdata};

   always_comb begin
      state_in   = state_ff;
      period_in  = period_ff;
      start_in   = start_ff;
      sum_in     = sum_ff;
      bar_in     = bar_ff;
      emitted_in = emitted_ff;
      ptr_in     = ptr_ff;
      held_in    = held_ff;
      oldest_in  = oldest_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_is_last) begin
                  // close the series
                  sum_in     = '0;
                  bar_in     = '0;
                  emitted_in = '0;
                  ptr_in     = '0;
                  held_in    = '0;
               end else begin
                  sum_in    = total;
                  held_in   = held_next;
                  ptr_in    = ptr_next;
                  bar_in    = bar_ff + COUNT_W'(1);
                  oldest_in = AW'(oldest_wide);
                  if (emit) begin
                     emitted_in = emitted_ff + COUNT_W'(1);
                  end
                  if (fill) begin
                     state_in = F_READ;
                  end
               end
            end
         end
         F_READ: begin
            state_in = F_UPD;
         end
         F_UPD: begin
            // drop the oldest range from the window
            sum_in   = sum_ff - oldest_range;
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_PERIOD: begin
               period_in  = csr_wdata[PERIOD_W-1:0];
               sum_in     = '0;
               bar_in     = '0;
               emitted_in = '0;
               ptr_in     = '0;
               held_in    = '0;
            end
            CSR_START_INDEX: begin
               start_in = csr_wdata[START_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         period_ff  <= PERIOD_RESET;
         start_ff   <= START_RESET;
         sum_ff     <= '0;
         bar_ff     <= '0;
         emitted_ff <= '0;
         ptr_ff     <= '0;
         held_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         period_ff  <= period_in;
         start_ff   <= start_in;
         sum_ff     <= sum_in;
         bar_ff     <= bar_in;
         emitted_ff <= emitted_in;
         ptr_ff     <= ptr_in;
         held_ff    <= held_in;
      end
      oldest_ff <= oldest_in;
   end

   assign job_push   = accept && emit;
   assign job_total  = total;
   assign job_period = eff_period;
   assign job_bar    = bar_ff;
   assign job_number = emitted_ff + COUNT_W'(1);
   assign job_last   = req_is_last;

endmodule

// File: sv/mar_queue.sv
// ----------------------------------------------------------------------------
// mar_queue
// Short job queue in flops between the front end and the divider.
// ----------------------------------------------------------------------------
module mar_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   import mar_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == QCW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCW'(1);
         2'b01:   count_in = count_ff - QCW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/mar_back.sv
// ----------------------------------------------------------------------------
// mar_back
// Back end: bit-serial signed divide of the window sum by the period, one
// quotient bit per cycle, into a result register.
// ----------------------------------------------------------------------------
module mar_back #(
   parameter int MAX_PERIOD = mar_pkg::MAX_PERIOD_DEF,
   parameter int PRICE_BITS = mar_pkg::PRICE_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // job queue
   input  logic                                          job_valid,
   output logic                                          job_pop,
   input  logic signed [PRICE_BITS+$clog2(MAX_PERIOD):0] job_total,
   input  logic [$clog2(MAX_PERIOD+1)-1:0]               job_period,
   input  logic [mar_pkg::COUNT_W-1:0]                   job_bar,
   input  logic [mar_pkg::COUNT_W-1:0]                   job_number,
   input  logic                                          job_last,
   // result output
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic signed [PRICE_BITS:0]                    rsp_average_range,
   output logic [mar_pkg::COUNT_W-1:0]                   rsp_bar_index,
   output logic [mar_pkg::COUNT_W-1:0]                   rsp_output_number,
   output logic                                          rsp_last_output
);

   import mar_pkg::*;

   localparam int PW = $clog2(MAX_PERIOD + 1);
   localparam int AVW = PRICE_BITS + 1;
   localparam int SW = AVW + $clog2(MAX_PERIOD);
   localparam int CW = $clog2(SW + 1);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [SW-1:0]          dvd_ff, dvd_in;
   logic [PW-1:0]          rem_ff, rem_in;
   logic [PW-1:0]          div_ff, div_in;
   logic                   neg_ff, neg_in;
   logic [CW-1:0]          step_ff, step_in;
   logic [COUNT_W-1:0]     bar_ff, bar_in;
   logic [COUNT_W-1:0]     num_ff, num_in;
   logic                   last_ff, last_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [AVW-1:0]  avg_ff, avg_in;
   logic [COUNT_W-1:0]     rsp_bar_ff, rsp_bar_in;
   logic [COUNT_W-1:0]     rsp_num_ff, rsp_num_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [PW:0]            trial;
   logic                   fits;
   logic [AVW-1:0]         quot;
   logic                   out_free;

   assign trial    = {rem_ff, dvd_ff[SW-1]};
   assign fits     = trial >= {1'b0, div_ff};
   assign quot     = dvd_ff[AVW-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign job_pop  = (state_ff == B_IDLE) && job_valid;

   always_comb begin
      state_in     = state_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      bar_in       = bar_ff;
      num_in       = num_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      avg_in       = avg_ff;
      rsp_bar_in   = rsp_bar_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               // divide magnitudes, restore the sign at the end
               neg_in   = job_total[SW-1];
               dvd_in   = job_total[SW-1] ? SW'(-job_total) : SW'(job_total);
               rem_in   = '0;
               div_in   = job_period;
               step_in  = '0;
               bar_in   = job_bar;
               num_in   = job_number;
               last_in  = job_last;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            rem_in  = fits ? PW'(trial - {1'b0, div_ff}) : PW'(trial);
            dvd_in  = {dvd_ff[SW-2:0], fits};
            step_in = step_ff + CW'(1);
            if (step_ff == CW'(SW - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               avg_in       = neg_ff ? -$signed(quot) : $signed(quot);
               rsp_bar_in   = bar_ff;
               rsp_num_in   = num_ff;
               rsp_last_in  = last_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      bar_ff      <= bar_in;
      num_ff      <= num_in;
      last_ff     <= last_in;
      avg_ff      <= avg_in;
      rsp_bar_ff  <= rsp_bar_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average_range = avg_ff;
   assign rsp_bar_index     = rsp_bar_ff;
   assign rsp_output_number = rsp_num_ff;
   assign rsp_last_output   = rsp_last_ff;

endmodule

// File: sv/moving_average_range.sv
// ----------------------------------------------------------------------------
// moving_average_range
// Simple moving average of bar range (high minus low) over a programmable
// window, with a start index, output numbering and end-of-series clear.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  high_price, low_price, is_last
//   rsp      out  rsp_valid/rsp_ready  average_range, bar_index,
//                                      output_number, last_output
//   csr      in   csr_we               csr_index, csr_wdata
//
// The front end takes a bar in F_IDLE, then F_READ and F_UPD when the window
// is full (one ring read to retire the oldest range). The back end divides
// each SW-bit sum serially, SW = PRICE_BITS + 1 + clog2(MAX_PERIOD), 41 at
// the defaults; that serial divide sets the sustained rate of results.
// A two-entry job queue lets the front end keep taking bars while the
// divider works or the result register waits on rsp_ready.
// Reset is synchronous; the range ring needs no clearing pass.
// ----------------------------------------------------------------------------
module moving_average_range #(
   parameter int MAX_PERIOD = mar_pkg::MAX_PERIOD_DEF,
   parameter int PRICE_BITS = mar_pkg::PRICE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [PRICE_BITS-1:0]         req_high_price,
   input  logic [PRICE_BITS-1:0]         req_low_price,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [PRICE_BITS:0]    rsp_average_range,
   output logic [mar_pkg::COUNT_W-1:0]   rsp_bar_index,
   output logic [mar_pkg::COUNT_W-1:0]   rsp_output_number,
   output logic                          rsp_last_output,
   input  logic                          csr_we,
   input  logic [mar_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mar_pkg::CSR_W-1:0]     csr_wdata
);

   import mar_pkg::*;

   localparam int PW = $clog2(MAX_PERIOD + 1);
   localparam int SW = PRICE_BITS + 1 + $clog2(MAX_PERIOD);
   localparam int JW = SW + PW + COUNT_W + COUNT_W + 1;

   logic                  push, full, pop, empty;
   logic signed [SW-1:0]  f_total, b_total;
   logic [PW-1:0]         f_period, b_period;
   logic [COUNT_W-1:0]    f_bar, b_bar;
   logic [COUNT_W-1:0]    f_number, b_number;
   logic                  f_last, b_last;
   logic [JW-1:0]         push_data, pop_data;

   mar_front #(
      .MAX_PERIOD (MAX_PERIOD),
      .PRICE_BITS (PRICE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_high_price (req_high_price),
      .req_low_price  (req_low_price),
      .req_is_last    (req_is_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .job_full       (full),
      .job_push       (push),
      .job_total      (f_total),
      .job_period     (f_period),
      .job_bar        (f_bar),
      .job_number     (f_number),
      .job_last       (f_last)
   );

   assign push_data = {f_total, f_period, f_bar, f_number, f_last};

   mar_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   assign {b_total, b_period, b_bar, b_number, b_last} = pop_data;

   mar_back #(
      .MAX_PERIOD (MAX_PERIOD),
      .PRICE_BITS (PRICE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (!empty),
      .job_pop           (pop),
      .job_total         (b_total),
      .job_period        (b_period),
      .job_bar           (b_bar),
      .job_number        (b_number),
      .job_last          (b_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_average_range (rsp_average_range),
      .rsp_bar_index     (rsp_bar_index),
      .rsp_output_number (rsp_output_number),
      .rsp_last_output   (rsp_last_output)
   );

endmodule

// File: sv/mar_checker.sv
// ----------------------------------------------------------------------------
// mar_checker
// Port-level checks on the moving average block, bound to the top level.
// ----------------------------------------------------------------------------
module mar_checker #(
   parameter int PRICE_BITS = mar_pkg::PRICE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [PRICE_BITS:0]    rsp_average_range,
   input logic [mar_pkg::COUNT_W-1:0]   rsp_bar_index,
   input logic [mar_pkg::COUNT_W-1:0]   rsp_output_number,
   input logic                          rsp_last_output
);

   import mar_pkg::*;

   logic [COUNT_W-1:0] last_num_ff, last_num_in;
   logic [COUNT_W-1:0] pend_ff, pend_in;
   logic               req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // track the last transferred number and bars not yet answered
   always_comb begin
      last_num_in = rsp_xfer ? (rsp_last_output ? '0 : rsp_output_number) : last_num_ff;
      pend_in     = pend_ff + COUNT_W'(req_xfer) - COUNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_num_ff <= '0;
         pend_ff     <= '0;
      end else begin
         last_num_ff <= last_num_in;
         pend_ff     <= pend_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_range)
         && $stable(rsp_bar_index) && $stable(rsp_output_number)
         && $stable(rsp_last_output))
      else $error("stalled result changed");

   a_number_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_output_number == last_num_ff + COUNT_W'(1))
         || (rsp_output_number == COUNT_W'(1)))
      else $error("output number out of sequence");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result without a pending bar");

endmodule

bind moving_average_range mar_checker #(.PRICE_BITS(PRICE_BITS)) u_checker (.*);

// File: verif/moving_average_range_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_range_tb
// Self-checking bench for the bar-range moving average. Bars go in over the
// req channel and every accepted transfer is run through an in-bench model of
// the window (ring, running sum, held count, start index, end-of-series
// clear). Averages coming out of rsp are matched in order against the model.
// Directed bars cover price extremes, negative ranges, truncation, period 0
// and 511, start index and a last bar without an average. Random series
// follow under three idle mixes, after a long receiver hold-off.
// ----------------------------------------------------------------------------
module moving_average_range_tb;
   import mar_pkg::*;

   localparam int WINDOW_MAX    = MAX_PERIOD_DEF;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic signed [32:0] average;
      logic [31:0]        bar_index;
      logic [31:0]        output_number;
      logic               last;
   } range_avg_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [31:0]          req_high_price = '0;
   logic [31:0]          req_low_price = '0;
   logic                 req_is_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [32:0]   rsp_average_range;
   logic [COUNT_W-1:0]   rsp_bar_index;
   logic [COUNT_W-1:0]   rsp_output_number;
   logic                 rsp_last_output;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   moving_average_range dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_high_price    (req_high_price),
      .req_low_price     (req_low_price),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_average_range (rsp_average_range),
      .rsp_bar_index     (rsp_bar_index),
      .rsp_output_number (rsp_output_number),
      .rsp_last_output   (rsp_last_output),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // window model
   logic [8:0]  cfg_period;
   logic [31:0] cfg_start;
   longint      range_ring [WINDOW_MAX];
   longint      window_sum;
   logic [31:0] bar_count;
   logic [7:0]  ring_ptr;
   logic [31:0] emitted;
   int          held;

   range_avg_type expected_avgs [$];
   range_avg_type want;

   int send_idle_pct = 11;
   int rsp_idle_pct  = 60;
   int rsp_hold      = 0;
   int fail_count    = 0;
   int bars_sent     = 0;
   int avgs_checked  = 0;
   int csr_writes    = 0;
   int input_stalls  = 0;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch: %s", msg);
   endfunction

   function automatic int eff_period();
      if (cfg_period == 9'd0)
         return 1;
      if (cfg_period > WINDOW_MAX)
         return WINDOW_MAX;
      return int'(cfg_period);
   endfunction

   task automatic clear_series();
      foreach (range_ring[i])
         range_ring[i] = 0;
      window_sum = 0;
      bar_count  = '0;
      ring_ptr   = '0;
      emitted    = '0;
      held       = 0;
   endtask

   task automatic predict_bar(input logic [31:0] hi, input logic [31:0] lo, input logic last);
      int            p;
      longint        range_val;
      longint        total;
      longint        quot;
      logic [7:0]    oldest;
      range_avg_type res;
      p = eff_period();
      range_val = longint'({32'd0, hi}) - longint'({32'd0, lo});
      range_ring[ring_ptr] = range_val;
      if (held < WINDOW_MAX)
         held++;
      total = window_sum + range_val;
      if (held >= p) begin
         if (bar_count >= cfg_start) begin
            emitted++;
            quot = total / longint'(p);
            res.average       = quot[32:0];
            res.bar_index     = bar_count;
            res.output_number = emitted;
            res.last          = last;
            expected_avgs.push_back(res);
         end
         // retire the oldest range so the sum holds period-1 entries
         oldest = ring_ptr - 8'(p - 1);
         total -= range_ring[oldest];
      end
      window_sum = total;
      ring_ptr++;
      bar_count++;
      if (last)
         clear_series();
   endtask

   task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_high_price <= hi;
      req_low_price  <= lo;
      req_is_last    <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_bar(hi, lo, last);
      bars_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_avgs.size() != 0)
         @(posedge clock);
      // a bar without an average may still be in the front end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_PERIOD) begin
         cfg_period = data[8:0];
         clear_series();
      end else begin
         cfg_start = data;
      end
      csr_writes++;
   endtask

   task automatic reprogram(input bit set_period, input logic [31:0] period_data,
                            input bit set_start, input logic [31:0] start_data);
      wait_drained();
      if (set_period)
         csr_write(CSR_PERIOD, period_data);
      if (set_start)
         csr_write(CSR_START_INDEX, start_data);
      csr_we <= 1'b0;
   endtask

   task automatic test_price_extremes();
      reprogram(1'b1, 32'd1, 1'b1, 32'd0);
      send_bar(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_bar(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_bar(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_bar(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      send_bar(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
   endtask

   task automatic test_negative_truncation();
      // -3/2 must come out as -1, not -2
      reprogram(1'b1, 32'd2, 1'b0, '0);
      send_bar(32'd0, 32'd3, 1'b0);
      send_bar(32'd0, 32'd0, 1'b0);
      send_bar(32'd5, 32'd0, 1'b0);
      send_bar(32'd0, 32'd7, 1'b1);
   endtask

   task automatic test_period_zero();
      reprogram(1'b1, 32'd0, 1'b0, '0);
      send_bar(32'h0001_8000, 32'h0000_4000, 1'b0);
      send_bar(32'h0000_1000, 32'h0002_0000, 1'b1);
   endtask

   task automatic test_start_index();
      reprogram(1'b1, 32'd3, 1'b1, 32'd3);
      for (int k = 0; k < 6; k++)
         send_bar($urandom(), $urandom(), k == 5);
      reprogram(1'b0, '0, 1'b1, 32'hFFFF_FFFF);
      send_bar($urandom(), $urandom(), 1'b0);
      send_bar($urandom(), $urandom(), 1'b1);
   endtask

   task automatic test_last_without_average();
      reprogram(1'b1, 32'd4, 1'b1, 32'd0);
      send_bar(32'd100, 32'd10, 1'b0);
      send_bar(32'd200, 32'd20, 1'b1);
      for (int k = 0; k < 4; k++)
         send_bar($urandom(), $urandom(), k == 3);
   endtask

   task automatic test_window_extremes();
      reprogram(1'b1, 32'd256, 1'b0, '0);
      for (int k = 0; k < 258; k++)
         send_bar($urandom(), $urandom(), 1'b0);
      // 511 acts as the full window; the write also drops the open series
      reprogram(1'b1, 32'hFFFF_FFFF, 1'b0, '0);
      for (int k = 0; k < 257; k++)
         send_bar($urandom(), $urandom(), k == 256);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      reprogram(1'b1, 32'd1, 1'b1, 32'd0);
      rsp_hold = 500;
      for (int k = 0; k < 30; k++)
         send_bar($urandom(), $urandom(), k == 29);
      wait_drained();
   endtask

   task automatic test_random(input int sender_pct, input int receiver_pct, input int n_bars);
      int          target;
      int          sel;
      int          p_val;
      int          p_eff;
      int          len;
      int          series;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] pdata;
      logic [31:0] sdata;
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      target = bars_sent + n_bars;
      while (bars_sent < target) begin
         sel = $urandom_range(99);
         if (sel < 70)      p_val = $urandom_range(1, 8);
         else if (sel < 86) p_val = $urandom_range(9, 40);
         else if (sel < 92) p_val = 0;
         else if (sel < 97) p_val = $urandom_range(41, 120);
         else if (sel < 99) p_val = WINDOW_MAX;
         else               p_val = $urandom_range(257, 511);
         pdata = $urandom();
         pdata[8:0] = p_val[8:0];
         sel = $urandom_range(99);
         if (sel < 70)      sdata = 32'd0;
         else if (sel < 92) sdata = $urandom_range(0, 20);
         else if (sel < 96) sdata = 32'hFFFF_FFFF;
         else               sdata = $urandom();
         reprogram($urandom_range(9) < 8, pdata, $urandom_range(9) < 6, sdata);
         p_eff = eff_period();
         for (series = (p_eff > 40) ? 1 : $urandom_range(1, 3); series > 0; series--) begin
            if ($urandom_range(9) == 0)
               len = $urandom_range(1, p_eff);
            else
               len = p_eff + $urandom_range(0, (p_eff > 40) ? 8 : 2 * p_eff + 6);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: begin
                     hi = $urandom();
                     lo = $urandom();
                  end
                  4, 5, 6: begin
                     lo = $urandom();
                     hi = lo + $urandom_range(0, 32'h0003_0000);
                  end
                  7: begin
                     hi = $urandom();
                     lo = hi + $urandom_range(1, 32'h0001_0000);
                  end
                  8: begin
                     hi = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                     lo = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                  end
                  default: begin
                     hi = $urandom();
                     lo = hi;
                  end
               endcase
               // most series close with is_last; some run on into the next
               send_bar(hi, lo, (k == len - 1) && ($urandom_range(9) != 0));
            end
         end
      end
   endtask

   // receiver: random idling, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready)
         input_stalls++;
      if (!reset && rsp_valid && rsp_ready) begin
         avgs_checked++;
         if (expected_avgs.size() == 0) begin
            note_failure($sformatf("unexpected average %0d for bar %0d",
                                   rsp_average_range, rsp_bar_index));
         end else begin
            want = expected_avgs.pop_front();
            if (rsp_average_range !== want.average || rsp_bar_index !== want.bar_index ||
                rsp_output_number !== want.output_number ||
                rsp_last_output !== want.last)
               note_failure($sformatf(
                  "got avg %0d bar %0d num %0d last %0b, wanted avg %0d bar %0d num %0d last %0b",
                  rsp_average_range, rsp_bar_index, rsp_output_number, rsp_last_output,
                  want.average, want.bar_index, want.output_number, want.last));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d averages outstanding", expected_avgs.size());
      $display("FAILURE");
      $finish;
   end

   initial begin : run_tests
      int guard;
      cfg_period = PERIOD_RESET;
      cfg_start  = START_RESET;
      clear_series();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_price_extremes();
      test_negative_truncation();
      test_period_zero();
      test_start_index();
      test_last_without_average();
      test_window_extremes();
      test_backpressure();
      test_random(11, 60, 500);
      test_random(60, 11, 500);
      test_random(0, 0, 500);

      req_valid <= 1'b0;
      for (guard = 0; guard < 20000 && expected_avgs.size() != 0; guard++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_avgs.size() != 0)
         note_failure($sformatf("%0d averages never arrived", expected_avgs.size()));

      $display("Ran %0d bars through %0d register writes (periods 0..511, start index 0..max),",
               bars_sent, csr_writes);
      $display("checked %0d averages; input held off for %0d cycles; %0d mismatches.",
               avgs_checked, input_stalls, fail_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
sv/mar_pkg.sv
sv/mar_ram.sv
sv/mar_front.sv
sv/mar_queue.sv
sv/mar_back.sv
sv/moving_average_range.sv
sv/mar_checker.sv
verif/moving_average_range_tb.sv
